// ----- src/swm_pkg.sv -----
// swm_pkg: shared constants, types and compare helpers for the sliding window median
// used by swm_cell and sliding_window_median; no dependencies
`timescale 1ns / 1ps

package swm_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int SLOT_W       = $clog2(MAX_WINDOW);
  localparam int COUNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W        = 5;

  // configuration register indexes
  localparam logic [0:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [0:0] REG_SIGNED     = 1'b1;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SORT   = 2'd2;

  // one held sample and the ring slot it came from
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] val;
    logic [SLOT_W-1:0]       tag;
  } entry_t;

  // broadcast control shared by every cell
  typedef struct packed {
    logic [1:0]        op;
    logic              sgn;
    logic              full;
    logic [SLOT_W-1:0] oldest;
    entry_t            incoming;
  } cell_ctrl_t;

  // a > b under the current sign mode
  function automatic logic key_gt(input logic [SAMPLE_WIDTH-1:0] a,
                                  input logic [SAMPLE_WIDTH-1:0] b,
                                  input logic                    sgn);
    logic [SAMPLE_WIDTH-1:0] flip;
    flip = {sgn, {(SAMPLE_WIDTH-1){1'b0}}};
    return (a ^ flip) > (b ^ flip);
  endfunction

  // clamp the raw window length into the supported range
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    if (raw < LEN_W'(2)) begin
      res = LEN_W'(2);
    end else if (raw > LEN_W'(MAX_WINDOW)) begin
      res = LEN_W'(MAX_WINDOW);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// ----- src/swm_cell.sv -----
// swm_cell: one slot of the sorted chain; handles delete+insert and odd-even swaps
// depends on swm_pkg
`timescale 1ns / 1ps

module swm_cell (
  input  logic                clk,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic                valid_self,
  input  logic                valid_right,
  input  logic                pair_right,
  input  logic                pair_left,
  input  swm_pkg::entry_t     left,
  input  swm_pkg::entry_t     right,
  input  logic                del_in,
  input  logic                gtp_left,
  output swm_pkg::entry_t     word,
  output swm_pkg::entry_t     word_next,
  output logic                del_out,
  output logic                gtp_out
);
  import swm_pkg::*;

  logic   match;
  entry_t shifted;
  logic   shifted_valid;
  entry_t left_shifted;
  entry_t insert_word;
  entry_t sort_word;

  // deletion of the oldest sample closes the gap from the right
  assign match         = ctrl.full && valid_self && (word.tag == ctrl.oldest);
  assign del_out       = del_in || match;
  assign shifted       = del_out ? right : word;
  assign shifted_valid = del_out ? valid_right : valid_self;
  assign left_shifted  = del_in ? word : left;

  // empty slots rank above everything so the new word lands before them
  assign gtp_out = !shifted_valid || key_gt(shifted.val, ctrl.incoming.val, ctrl.sgn);

  always_comb begin
    if (!gtp_out) begin
      insert_word = shifted;
    end else if (!gtp_left) begin
      insert_word = ctrl.incoming;
    end else begin
      insert_word = left_shifted;
    end
  end

  // odd-even transposition step
  always_comb begin
    sort_word = word;
    if (pair_right && key_gt(word.val, right.val, ctrl.sgn)) begin
      sort_word = right;
    end else if (pair_left && key_gt(left.val, word.val, ctrl.sgn)) begin
      sort_word = left;
    end
  end

  // operation select
  always_comb begin
    unique case (ctrl.op)
      OP_INSERT: word_next = insert_word;
      OP_SORT:   word_next = sort_word;
      default:   word_next = word;
    endcase
  end

  // held word
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- src/sliding_window_median.sv -----
// sliding_window_median: running median over a window of up to 16 samples
// built from a chain of swm_cell slots; depends on swm_pkg and swm_cell
`timescale 1ns / 1ps
//
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   sample[15:0]
// output    out        out_valid / out_ready median[15:0]
// config    in         cfg_we (no wait)      cfg_index[0], cfg_data[4:0]
//
// one sample per cycle while in_ready is high: the chain removes the oldest word
// and inserts the new one in a single step, and the median register loads at the
// same edge. a write to signed_samples starts an odd-even resort of the chain;
// in_ready stays low during it. writing window_len empties the window at once.
// reset (rst, synchronous) clears the counters and the output valid.
// in_ready drops while a median waits and out_ready is low.

module sliding_window_median (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swm_pkg::SAMPLE_WIDTH-1:0]  sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swm_pkg::SAMPLE_WIDTH-1:0]  median,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [swm_pkg::LEN_W-1:0]         cfg_data
);
  import swm_pkg::*;

  logic [LEN_W-1:0]   window_len;
  logic               signed_samples;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [COUNT_W-1:0] fill_count;
  logic               sorting;
  logic [SLOT_W-1:0]  sort_cnt;
  logic               sort_phase;

  logic               accept;
  logic [LEN_W-1:0]   len;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  oldest_slot_next;
  logic               full;
  logic [COUNT_W-1:0] fill_count_next;
  logic [LEN_W-1:0]   half_len;
  logic [LEN_W-1:0]   last_idx;
  logic [LEN_W-1:0]   rank_full;
  logic [SLOT_W-1:0]  rank;
  cell_ctrl_t         ctrl;

  entry_t cur [MAX_WINDOW];
  entry_t nxt [MAX_WINDOW];
  logic   del_chain [MAX_WINDOW];
  logic   gtp_chain [MAX_WINDOW];

  assign accept   = in_valid && in_ready;
  assign in_ready = !sorting && (!out_valid || out_ready);

  // ring slot bookkeeping
  always_comb begin
    len  = eff_len(window_len);
    slot = (LEN_W'(oldest_slot) >= len) ? '0 : oldest_slot;
    if (LEN_W'(slot) + LEN_W'(1) == len) begin
      oldest_slot_next = '0;
    end else begin
      oldest_slot_next = slot + SLOT_W'(1);
    end
    full            = LEN_W'(fill_count) >= len;
    fill_count_next = full ? COUNT_W'(len) : fill_count + COUNT_W'(1);
    half_len        = len >> 1;
    last_idx        = LEN_W'(fill_count_next) - LEN_W'(1);
    rank_full       = (half_len < last_idx) ? half_len : last_idx;
    rank            = rank_full[SLOT_W-1:0];
  end

  // broadcast control
  always_comb begin
    ctrl.op           = accept ? OP_INSERT : (sorting ? OP_SORT : OP_HOLD);
    ctrl.sgn          = signed_samples;
    ctrl.full         = full;
    ctrl.oldest       = slot;
    ctrl.incoming.val = sample;
    ctrl.incoming.tag = slot;
  end

  // chain of cells
  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    entry_t left_word;
    entry_t right_word;
    logic   del_left;
    logic   gtp_left;
    logic   valid_self;
    logic   valid_right;
    logic   pair_right;
    logic   pair_left;

    if (j == 0) begin : g_first
      assign left_word = '0;
      assign del_left  = 1'b0;
      assign gtp_left  = 1'b0;
      assign pair_left = 1'b0;
    end else begin : g_inner_left
      assign left_word = cur[j-1];
      assign del_left  = del_chain[j-1];
      assign gtp_left  = gtp_chain[j-1];
      assign pair_left = sorting && (1'((j - 1) % 2) == sort_phase) && valid_self;
    end

    if (j == MAX_WINDOW - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_right
      assign right_word = cur[j+1];
    end

    assign valid_self  = COUNT_W'(j) < fill_count;
    assign valid_right = COUNT_W'(j + 1) < fill_count;
    assign pair_right  = sorting && (1'(j % 2) == sort_phase) && valid_right;

    swm_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid_self  (valid_self),
      .valid_right (valid_right),
      .pair_right  (pair_right),
      .pair_left   (pair_left),
      .left        (left_word),
      .right       (right_word),
      .del_in      (del_left),
      .gtp_left    (gtp_left),
      .word        (cur[j]),
      .word_next   (nxt[j]),
      .del_out     (del_chain[j]),
      .gtp_out     (gtp_chain[j])
    );
  end

  // configuration, window counters and resort sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= LEN_W'(MAX_WINDOW);
      signed_samples <= 1'b0;
      oldest_slot    <= '0;
      fill_count     <= '0;
      sorting        <= 1'b0;
      sort_cnt       <= '0;
      sort_phase     <= 1'b0;
    end else begin
      if (accept) begin
        oldest_slot <= oldest_slot_next;
        fill_count  <= fill_count_next;
      end
      if (sorting) begin
        sort_phase <= !sort_phase;
        sort_cnt   <= sort_cnt - SLOT_W'(1);
        if (sort_cnt == '0) begin
          sorting <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len  <= cfg_data;
            oldest_slot <= '0;
            fill_count  <= '0;
          end
          REG_SIGNED: begin
            signed_samples <= cfg_data[0];
            sorting        <= 1'b1;
            sort_cnt       <= SLOT_W'(MAX_WINDOW - 1);
            sort_phase     <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median <= nxt[rank].val;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= COUNT_W'(MAX_WINDOW))
    else $error("fill count beyond window");

  a_no_accept_in_sort: assert property (@(posedge clk) disable iff (rst)
    sorting |-> !in_ready)
    else $error("input taken during resort");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_sort_ends: assert property (@(posedge clk) disable iff (rst)
    (sorting && sort_cnt == '0 && !cfg_we) |=> !sorting)
    else $error("resort did not finish");
`endif

endmodule
